### hw/rtl/aabb_move_blocker_assert.svh
// Assertion macros for the move blocker RTL.
`ifndef AABB_MOVE_BLOCKER_ASSERT_SVH
`define AABB_MOVE_BLOCKER_ASSERT_SVH

// Same-cycle implication, checked outside of reset.
`define AMB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside of reset.
`define AMB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/amb_pkg.sv
// Package with the item layouts of the move blocker.
`default_nettype none

package amb_pkg;

  localparam int unsigned AMB_FIELD_W = 32;
  localparam int unsigned AMB_IN_W    = 12 * AMB_FIELD_W;
  localparam int unsigned AMB_OUT_W   = 2 * AMB_FIELD_W;

  // Declared from the highest bits down, so box_left sits in the lowest bits.
  typedef struct packed {
    logic signed [AMB_FIELD_W-1:0] obst_bottom;
    logic signed [AMB_FIELD_W-1:0] obst_right;
    logic signed [AMB_FIELD_W-1:0] obst_top;
    logic signed [AMB_FIELD_W-1:0] obst_left;
    logic signed [AMB_FIELD_W-1:0] want_y;
    logic signed [AMB_FIELD_W-1:0] want_x;
    logic signed [AMB_FIELD_W-1:0] old_y;
    logic signed [AMB_FIELD_W-1:0] old_x;
    logic signed [AMB_FIELD_W-1:0] box_bottom;
    logic signed [AMB_FIELD_W-1:0] box_right;
    logic signed [AMB_FIELD_W-1:0] box_top;
    logic signed [AMB_FIELD_W-1:0] box_left;
  } amb_query_t;

  typedef struct packed {
    logic                          was_inside;
    logic signed [AMB_FIELD_W-1:0] allowed_y;
    logic signed [AMB_FIELD_W-1:0] allowed_x;
  } amb_result_t;

endpackage

`default_nettype wire

### hw/rtl/amb_clamp.sv
// Clamps one axis of a move so the item stops at the obstacle's edge.
`default_nettype none

module amb_clamp #(
  parameter int unsigned COORD_WIDTH = 32
) (
  input  wire logic signed [COORD_WIDTH-1:0] delta_i,
  input  wire logic                          perp_ov_i,
  input  wire logic signed [COORD_WIDTH-1:0] lo_i,
  input  wire logic signed [COORD_WIDTH-1:0] hi_i,
  input  wire logic signed [COORD_WIDTH-1:0] obst_lo_i,
  input  wire logic signed [COORD_WIDTH-1:0] obst_hi_i,
  input  wire logic signed [COORD_WIDTH-1:0] pos_i,
  input  wire logic signed [COORD_WIDTH-1:0] want_i,
  output logic signed [COORD_WIDTH-1:0]      coord_o
);

  logic                          d_pos;
  logic                          d_neg;
  logic signed [COORD_WIDTH-1:0] lim_fwd;
  logic signed [COORD_WIDTH-1:0] lim_bwd;
  logic signed [COORD_WIDTH-1:0] step_fwd;
  logic signed [COORD_WIDTH-1:0] step_bwd;

  assign d_neg    = delta_i[COORD_WIDTH-1];
  assign d_pos    = !delta_i[COORD_WIDTH-1] && (delta_i != '0);
  assign lim_fwd  = obst_lo_i - hi_i;
  assign lim_bwd  = obst_hi_i - lo_i;
  assign step_fwd = (delta_i < lim_fwd) ? delta_i : lim_fwd;
  assign step_bwd = (lim_bwd < delta_i) ? delta_i : lim_bwd;

  always_comb begin
    coord_o = want_i;
    if (d_pos && perp_ov_i) begin
      coord_o = (hi_i < obst_lo_i) ? pos_i + step_fwd : pos_i;
    end else if (d_neg && perp_ov_i) begin
      coord_o = (obst_hi_i < lo_i) ? pos_i + step_bwd : pos_i;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/amb_core.sv
// Overlap test, push-out and clamp selection for one registered item.
`default_nettype none

module amb_core #(
  parameter int unsigned COORD_WIDTH = 32
) (
  input  amb_pkg::amb_query_t  query_i,
  output amb_pkg::amb_result_t result_o
);
  import amb_pkg::*;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  coord_t bl, bt, br, bb, ox, oy, wx, wy, ol, ot, orr, ob;
  coord_t dx, dy, sl, sr, st, sb;
  coord_t pl, pr, pu, pd, push_x, push_y;
  coord_t clamp_x, clamp_y;
  coord_t rx, ry;
  logic [COORD_WIDTH-1:0] mag_x, mag_y;
  logic xov, yov, box_ov;
  logic dx_pos, dx_neg, dy_pos, dy_neg;
  logic px_raw, py_raw, take_x, take_y;

  // Inputs are sign-extended or truncated to the working width.
  assign bl  = coord_t'($signed(query_i.box_left));
  assign bt  = coord_t'($signed(query_i.box_top));
  assign br  = coord_t'($signed(query_i.box_right));
  assign bb  = coord_t'($signed(query_i.box_bottom));
  assign ox  = coord_t'($signed(query_i.old_x));
  assign oy  = coord_t'($signed(query_i.old_y));
  assign wx  = coord_t'($signed(query_i.want_x));
  assign wy  = coord_t'($signed(query_i.want_y));
  assign ol  = coord_t'($signed(query_i.obst_left));
  assign ot  = coord_t'($signed(query_i.obst_top));
  assign orr = coord_t'($signed(query_i.obst_right));
  assign ob  = coord_t'($signed(query_i.obst_bottom));

  assign dx = wx - ox;
  assign dy = wy - oy;
  assign sl = bl + ox;
  assign sr = br + ox;
  assign st = bt + oy;
  assign sb = bb + oy;

  assign xov    = (ol < sr) && (sl < orr);
  assign yov    = (ot < sb) && (st < ob);
  assign box_ov = xov && yov;

  assign dx_neg = dx[COORD_WIDTH-1];
  assign dx_pos = !dx[COORD_WIDTH-1] && (dx != '0);
  assign dy_neg = dy[COORD_WIDTH-1];
  assign dy_pos = !dy[COORD_WIDTH-1] && (dy != '0);

  assign pl = ol - sr;
  assign pr = orr - sl;
  assign pu = ot - sb;
  assign pd = ob - st;

  assign px_raw = (dx_pos && pl[COORD_WIDTH-1]) ||
                  (dx_neg && !pr[COORD_WIDTH-1] && (pr != '0));
  assign py_raw = (dy_pos && pu[COORD_WIDTH-1]) ||
                  (dy_neg && !pd[COORD_WIDTH-1] && (pd != '0));
  assign push_x = dx_pos ? pl : pr;
  assign push_y = dy_pos ? pu : pd;

  // Magnitudes are unsigned, so the most negative value still compares largest.
  assign mag_x = push_x[COORD_WIDTH-1] ? -push_x : push_x;
  assign mag_y = push_y[COORD_WIDTH-1] ? -push_y : push_y;

  // When both axes push, the smaller push wins and ties go to x.
  assign take_x = px_raw && (!py_raw || (mag_x <= mag_y));
  assign take_y = py_raw && !take_x;

  amb_clamp #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_clamp_x (
    .delta_i  (dx),
    .perp_ov_i(yov),
    .lo_i     (sl),
    .hi_i     (sr),
    .obst_lo_i(ol),
    .obst_hi_i(orr),
    .pos_i    (ox),
    .want_i   (wx),
    .coord_o  (clamp_x)
  );

  amb_clamp #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_clamp_y (
    .delta_i  (dy),
    .perp_ov_i(xov),
    .lo_i     (st),
    .hi_i     (sb),
    .obst_lo_i(ot),
    .obst_hi_i(ob),
    .pos_i    (oy),
    .want_i   (wy),
    .coord_o  (clamp_y)
  );

  always_comb begin
    if (box_ov) begin
      rx = take_x ? ox + push_x : wx;
      ry = take_y ? oy + push_y : wy;
    end else begin
      rx = clamp_x;
      ry = clamp_y;
    end
  end

  assign result_o.allowed_x  = AMB_FIELD_W'(rx);
  assign result_o.allowed_y  = AMB_FIELD_W'(ry);
  assign result_o.was_inside = box_ov;

endmodule

`default_nettype wire

### hw/rtl/aabb_move_blocker.sv
// Top level of the axis-aligned box move blocker.
`default_nettype none
`include "aabb_move_blocker_assert.svh"

// The block takes one query item per clock cycle while s_axis_tready_o is high
// and returns one result item for each, in order. An item passes an input
// register, the overlap, push-out and clamp logic, and a result register, and
// its result is offered at the output once it is in the result register. The
// input register keeps taking items while a finished result waits at the
// output; the block stops taking items only when both registers are full.
// Coordinates are worked at COORD_WIDTH bits and wrap; the 32-bit results are
// the low bits of that, sign-extended when COORD_WIDTH is below 32.
module aabb_move_blocker #(
  parameter int unsigned COORD_WIDTH = 32
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // box_left, box_top, box_right, box_bottom, old_x, old_y, want_x, want_y,
  // obst_left, obst_top, obst_right, obst_bottom (32 bits each, lowest first)
  input  wire logic [amb_pkg::AMB_IN_W-1:0] s_axis_tdata_i,
  output logic                              m_axis_tvalid_o,
  input  wire logic                         m_axis_tready_i,
  // allowed_x [31:0], allowed_y [63:32]
  output logic [amb_pkg::AMB_OUT_W-1:0]     m_axis_tdata_o,
  // was_inside
  output logic                              m_axis_tuser_o
);
  import amb_pkg::*;

  logic        in_valid_q;
  amb_query_t  query_q;
  logic        out_valid_q;
  amb_result_t result_q;
  amb_result_t result_d;
  logic        adv_out;
  logic        adv_in;

  assign adv_out = !out_valid_q || m_axis_tready_i;
  assign adv_in  = !in_valid_q || adv_out;

  assign s_axis_tready_o = adv_in;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (adv_in) begin
        in_valid_q <= s_axis_tvalid_i;
      end
      if (adv_out) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_in && s_axis_tvalid_i) begin
      query_q <= amb_query_t'(s_axis_tdata_i);
    end
    if (adv_out && in_valid_q) begin
      result_q <= result_d;
    end
  end

  amb_core #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_core (
    .query_i (query_q),
    .result_o(result_d)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {result_q.allowed_y, result_q.allowed_x};
  assign m_axis_tuser_o  = result_q.was_inside;

  `AMB_ASSERT_NEXT(a_accept_fills_input, s_axis_tvalid_i && s_axis_tready_o, in_valid_q, "accepted item did not reach the input register")
  `AMB_ASSERT_NEXT(a_input_moves_out, in_valid_q && adv_out, m_axis_tvalid_o, "registered item did not reach the result register")
  `AMB_ASSERT_NOW(a_ready_when_empty, !in_valid_q || !m_axis_tvalid_o, s_axis_tready_o, "input not ready although a register is free")

endmodule

`default_nettype wire
